// ----- design/kmd_pkg.sv -----
// Package for the key matrix debounce block: widths, reset values, register
// indexes, state encoding, sweep status struct and note saturation.
// No dependencies.
`default_nettype none

package kmd_pkg;

  localparam int KEY_COUNT_DEF = 64;
  localparam int RAW_W         = 64;
  localparam int IDX_W         = 6;
  localparam int NOTE_W        = 7;
  localparam int VEL_W         = 7;
  localparam int CHAN_W        = 5;
  localparam int THR_W         = 4;
  localparam int CFG_DATA_W    = 7;
  localparam int CFG_IDX_W     = 2;

  localparam logic [THR_W-1:0]  THR_RST  = 4'd3;
  localparam logic [NOTE_W-1:0] BASE_RST = 7'd48;
  localparam logic [VEL_W-1:0]  VEL_RST  = 7'd100;
  localparam logic [CHAN_W-1:0] CHAN_RST = 5'd1;
  localparam logic [NOTE_W-1:0] NOTE_MAX = 7'd127;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD = 2'd0,
    CFG_BASE_NOTE = 2'd1,
    CFG_VELOCITY  = 2'd2,
    CFG_CHANNEL   = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_EMIT
  } state_t;

  // one key per cycle out of the debounce sweep
  typedef struct packed {
    logic valid;
    logic changed;
    logic pressed;
    logic done;
  } sweep_step_t;

  function automatic logic [NOTE_W-1:0] note_sat(input logic [NOTE_W-1:0] base,
                                                 input logic [IDX_W-1:0]  idx);
    logic [NOTE_W:0] sum;
    sum = {1'b0, base} + {2'b00, idx};
    note_sat = sum[NOTE_W] ? NOTE_MAX : sum[NOTE_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- design/kmd_if.sv -----
// Request channel interfaces for the key matrix debounce block:
// scan input channel and note event output channel. Uses kmd_pkg.
`default_nettype none

interface kmd_in_if;
  logic                        valid;
  logic                        ready;
  logic [kmd_pkg::RAW_W-1:0]   raw_keys;

  modport source (output valid, output raw_keys, input ready);
  modport sink   (input valid, input raw_keys, output ready);
endinterface

interface kmd_out_if;
  logic                        valid;
  logic                        ready;
  logic [kmd_pkg::IDX_W-1:0]   key_id;
  logic [kmd_pkg::NOTE_W-1:0]  note_number;
  logic                        is_press;
  logic [kmd_pkg::VEL_W-1:0]   velocity;
  logic [kmd_pkg::CHAN_W-1:0]  channel_out;
  logic                        last;

  modport source (output valid, output key_id, output note_number, output is_press,
                  output velocity, output channel_out, output last, input ready);
  modport sink   (input valid, input key_id, input note_number, input is_press,
                  input velocity, input channel_out, input last, output ready);
endinterface

`default_nettype wire

// ----- design/kmd_sweep.sv -----
// Bit-serial debounce sweep: rotates the stable mask and the per-key counters
// past one update cell, one key per cycle. Uses kmd_pkg.
`default_nettype none

module kmd_sweep #(
  parameter int KEY_COUNT = kmd_pkg::KEY_COUNT_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [KEY_COUNT-1:0]         raw,
  input  wire logic [kmd_pkg::THR_W-1:0]    thr,
  output kmd_pkg::sweep_step_t              step
);

  localparam int KI_W = $clog2(KEY_COUNT);

  logic                       busy_r;
  logic [KI_W-1:0]            key_r;
  logic [KEY_COUNT-1:0]       raw_sr_r;
  logic [KEY_COUNT-1:0]       stable_r;
  logic [kmd_pkg::THR_W-1:0]  cnt_r [KEY_COUNT];

  logic                       s_nxt;
  logic [kmd_pkg::THR_W-1:0]  c_nxt;
  logic [kmd_pkg::THR_W:0]    c_inc;
  logic                       done;

  always_comb begin
    c_inc = {1'b0, cnt_r[0]} + 5'd1;
    s_nxt = stable_r[0];
    c_nxt = '0;
    if (raw_sr_r[0] != stable_r[0]) begin
      if (c_inc >= {1'b0, thr}) begin
        s_nxt = raw_sr_r[0];
      end else begin
        c_nxt = c_inc[kmd_pkg::THR_W-1:0];
      end
    end
  end

  assign done = busy_r && (key_r == KI_W'(KEY_COUNT - 1));

  assign step.valid   = busy_r;
  assign step.changed = busy_r && (s_nxt != stable_r[0]);
  assign step.pressed = s_nxt;
  assign step.done    = done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      key_r    <= '0;
      stable_r <= '0;
      for (int i = 0; i < KEY_COUNT; i++) cnt_r[i] <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      key_r  <= '0;
    end else if (busy_r) begin
      stable_r <= {s_nxt, stable_r[KEY_COUNT-1:1]};
      for (int i = 0; i < KEY_COUNT - 1; i++) cnt_r[i] <= cnt_r[i+1];
      cnt_r[KEY_COUNT-1] <= c_nxt;
      key_r <= key_r + 1'b1;
      if (done) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      raw_sr_r <= raw;
    end else if (busy_r) begin
      raw_sr_r <= raw_sr_r >> 1;
    end
  end

endmodule

`default_nettype wire

// ----- design/key_matrix_debounce_note_events.sv -----
// Flow: a scan request is swept key by key through kmd_sweep; changed keys are then
// emitted in key order from the registered output, unchanged keys skipped.
// A new scan is taken only in idle, once the last event of the previous scan is
// loaded; the emit phase waits on output stalls.
// Reset (synchronous, rst_n low): stable keys and counters cleared,
// registers to threshold 3, base note 48, velocity 100, channel 1.
`default_nettype none

module key_matrix_debounce_note_events #(
  parameter int KEY_COUNT = kmd_pkg::KEY_COUNT_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  kmd_in_if.sink                                in_chan,
  kmd_out_if.source                             out_chan,
  input  wire logic                             cfg_we,
  input  wire logic [kmd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [kmd_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int KI_W = $clog2(KEY_COUNT);
  localparam int CN_W = $clog2(KEY_COUNT + 1);

  kmd_pkg::state_t             state_r, state_nxt;
  logic [kmd_pkg::THR_W-1:0]   thr_r;
  logic [kmd_pkg::NOTE_W-1:0]  base_r;
  logic [kmd_pkg::VEL_W-1:0]   vel_r;
  logic [kmd_pkg::CHAN_W-1:0]  chan_r;
  logic [kmd_pkg::THR_W-1:0]   thr_eff;

  logic [KEY_COUNT-1:0]        chg_r;
  logic [KEY_COUNT-1:0]        prs_r;
  logic [CN_W-1:0]             left_r, left_nxt;
  logic [KI_W-1:0]             idx_r;

  logic                        out_valid_r;
  logic [kmd_pkg::IDX_W-1:0]   key_id_r;
  logic [kmd_pkg::NOTE_W-1:0]  note_r;
  logic                        press_r;
  logic [kmd_pkg::VEL_W-1:0]   velo_r;
  logic [kmd_pkg::CHAN_W-1:0]  chan_out_r;
  logic                        last_r;

  kmd_pkg::sweep_step_t        step;
  logic                        accept;
  logic                        out_free;
  logic                        load;
  logic                        advance;

  assign thr_eff = (thr_r == '0) ? 4'd1 : thr_r;
  assign accept  = in_chan.valid && in_chan.ready;
  assign in_chan.ready = (state_r == kmd_pkg::ST_IDLE);
  assign out_free = !out_valid_r || out_chan.ready;

  kmd_sweep #(.KEY_COUNT(KEY_COUNT)) u_sweep (
    .clk   (clk),
    .rst_n (rst_n),
    .start (accept),
    .raw   (in_chan.raw_keys[KEY_COUNT-1:0]),
    .thr   (thr_eff),
    .step  (step)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= kmd_pkg::THR_RST;
      base_r <= kmd_pkg::BASE_RST;
      vel_r  <= kmd_pkg::VEL_RST;
      chan_r <= kmd_pkg::CHAN_RST;
    end else if (cfg_we) begin
      case (kmd_pkg::cfg_idx_t'(cfg_index))
        kmd_pkg::CFG_THRESHOLD: thr_r  <= cfg_data[kmd_pkg::THR_W-1:0];
        kmd_pkg::CFG_BASE_NOTE: base_r <= cfg_data[kmd_pkg::NOTE_W-1:0];
        kmd_pkg::CFG_VELOCITY:  vel_r  <= cfg_data[kmd_pkg::VEL_W-1:0];
        kmd_pkg::CFG_CHANNEL:   chan_r <= cfg_data[kmd_pkg::CHAN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    left_nxt  = left_r;
    load      = 1'b0;
    advance   = 1'b0;
    case (state_r)
      kmd_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = kmd_pkg::ST_SWEEP;
          left_nxt  = '0;
        end
      end
      kmd_pkg::ST_SWEEP: begin
        if (step.changed) begin
          left_nxt = left_r + 1'b1;
        end
        if (step.done) begin
          state_nxt = (left_nxt == '0) ? kmd_pkg::ST_IDLE : kmd_pkg::ST_EMIT;
        end
      end
      kmd_pkg::ST_EMIT: begin
        load    = chg_r[0] && out_free;
        advance = !chg_r[0] || out_free;
        if (load) begin
          left_nxt = left_r - 1'b1;
          if (left_r == CN_W'(1)) begin
            state_nxt = kmd_pkg::ST_IDLE;
          end
        end
      end
      default: state_nxt = kmd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= kmd_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= '0;
      idx_r  <= '0;
    end else begin
      left_r <= left_nxt;
      if (step.done) begin
        idx_r <= '0;
      end else if (advance) begin
        idx_r <= idx_r + 1'b1;
      end
    end
  end

  // change and new-state bits, key 0 at bit 0 once the sweep ends
  always_ff @(posedge clk) begin
    if (step.valid) begin
      chg_r <= {step.changed, chg_r[KEY_COUNT-1:1]};
      prs_r <= {step.pressed, prs_r[KEY_COUNT-1:1]};
    end else if (advance) begin
      chg_r <= chg_r >> 1;
      prs_r <= prs_r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      key_id_r    <= kmd_pkg::IDX_W'(idx_r);
      note_r      <= kmd_pkg::note_sat(base_r, kmd_pkg::IDX_W'(idx_r));
      press_r     <= prs_r[0];
      velo_r      <= prs_r[0] ? vel_r : '0;
      chan_out_r  <= chan_r;
      last_r      <= (left_r == CN_W'(1));
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.key_id      = key_id_r;
  assign out_chan.note_number = note_r;
  assign out_chan.is_press    = press_r;
  assign out_chan.velocity    = velo_r;
  assign out_chan.channel_out = chan_out_r;
  assign out_chan.last        = last_r;

endmodule

`default_nettype wire

// ----- design/kmd_checker.sv -----
// Port-level checks for the key matrix debounce block, bound to the top level.
// Depends on kmd_pkg and the top level's channel interfaces.
`default_nettype none

module kmd_checker (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             in_valid,
  input wire logic                             in_ready,
  input wire logic                             out_valid,
  input wire logic                             out_ready,
  input wire logic [kmd_pkg::IDX_W-1:0]        key_id,
  input wire logic [kmd_pkg::NOTE_W-1:0]       note_number,
  input wire logic                             is_press,
  input wire logic [kmd_pkg::VEL_W-1:0]        velocity,
  input wire logic                             last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(key_id) && $stable(note_number)
      && $stable(is_press) && $stable(velocity) && $stable(last))
    else $error("stalled event request changed");

  a_busy_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("scan request taken while sweep should be running");

  a_release_vel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !is_press |-> velocity == '0)
    else $error("note off with nonzero velocity");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("event request right after reset");

endmodule

bind key_matrix_debounce_note_events kmd_checker u_kmd_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_chan.valid),
  .in_ready    (in_chan.ready),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .key_id      (out_chan.key_id),
  .note_number (out_chan.note_number),
  .is_press    (out_chan.is_press),
  .velocity    (out_chan.velocity),
  .last        (out_chan.last)
);

`default_nettype wire
